@@ design/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, expr) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error("assertion failed");

// antecedent at one edge implies consequent at the next edge
`define ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

@@ design/ile_pkg.sv @@
`default_nettype none

package ile_pkg;

   localparam int CAPACITY = 16;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int POS_W    = 5;
   localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;
   localparam int WORD_W   = 32;

   typedef enum logic [2:0] {
      OP_PUSH_BACK  = 3'd0,
      OP_PUSH_FRONT = 3'd1,
      OP_POP_BACK   = 3'd2,
      OP_POP_FRONT  = 3'd3,
      OP_INSERT_AT  = 3'd4,
      OP_DELETE_AT  = 3'd5,
      OP_REVERSE    = 3'd6,
      OP_READ_AT    = 3'd7
   } op_type;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_EMPTY  = 2'd1,
      ST_BADIDX = 2'd2,
      ST_FULL   = 2'd3
   } status_type;

   // what every cell of the chain does this cycle
   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_DELETE,
      CELL_ROTATE
   } cell_op_type;

   typedef struct packed {
      cell_op_type         op;
      logic [IDX_W-1:0]    pos;
      logic [WORD_W-1:0]   word;
   } cell_cmd_type;

   typedef enum logic {
      FSM_IDLE,
      FSM_REVERSE
   } fsm_type;

   typedef struct packed {
      status_type          status;
      logic [4:0]          item_count;
      logic [WORD_W-1:0]   read_value;
   } rsp_beat_type;

endpackage

`default_nettype wire

@@ design/ile_if.sv @@
`default_nettype none

// request channel
interface ile_req_if import ile_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [2:0]                req_type;
   logic [POS_W-1:0]          position;
   logic signed [WORD_W-1:0]  item_value;

   modport source (output valid, output req_type, output position, output item_value,
                   input ready);
   modport sink   (input valid, input req_type, input position, input item_value,
                   output ready);
endinterface

// result channel
interface ile_rsp_if import ile_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [1:0]                status;
   logic [4:0]                item_count;
   logic signed [WORD_W-1:0]  read_value;

   modport source (output valid, output status, output item_count, output read_value,
                   input ready);
   modport sink   (input valid, input status, input item_count, input read_value,
                   output ready);
endinterface

`default_nettype wire

@@ design/ile_cell.sv @@
`default_nettype none

module ile_cell import ile_pkg::*; (
   input  wire logic                clock,
   input  wire logic [IDX_W-1:0]    cell_index,
   input  wire cell_cmd_type        cmd,
   input  wire logic [WORD_W-1:0]   left_entry,
   input  wire logic [WORD_W-1:0]   right_entry,
   input  wire logic [WORD_W-1:0]   head_entry,
   output      logic [WORD_W-1:0]   entry
);

   logic [WORD_W-1:0] entry_ff;
   logic [WORD_W-1:0] entry_in;

   // pick own next word from the broadcast command and the neighbors
   always_comb begin
      entry_in = entry_ff;
      case (cmd.op)
         CELL_INSERT: begin
            if (cell_index > cmd.pos) begin
               entry_in = left_entry;
            end else if (cell_index == cmd.pos) begin
               entry_in = cmd.word;
            end
         end
         CELL_DELETE: begin
            if (cell_index >= cmd.pos) begin
               entry_in = right_entry;
            end
         end
         CELL_ROTATE: begin
            if (cell_index < cmd.pos) begin
               entry_in = right_entry;
            end else if (cell_index == cmd.pos) begin
               entry_in = head_entry;
            end
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   // payload register, no reset
   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

`default_nettype wire

@@ design/indexed_list_engine.sv @@
// Ordered list of signed 32-bit words, up to CAPACITY entries, kept in a row
// of cells that shift left or right in parallel.
// req_chan: one beat per request (push/pop at either end, insert, delete,
// reverse, read). rsp_chan: exactly one beat per request, in order, with
// status, count after the request and read data (zero unless a good read).
// Each result beat is registered in the output queue before it is offered.
// Throughput: one request per cycle while the output queue has room, for
// every kind but reverse; a reverse of more than one live entry keeps the
// input closed while passes rotate the head word into place along the cells.
// Results go into a two-beat output queue; while it is full the input is
// held off, so a stalled receiver backs up into the request channel after
// at most two beats, and no result is ever dropped.
// Reset (synchronous, active high) empties the list and the output queue;
// the stored words themselves are not cleared.
`default_nettype none

`include "assert_macros.svh"

module indexed_list_engine import ile_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   ile_req_if.sink      req_chan,
   ile_rsp_if.source    rsp_chan
);

   fsm_type              state_ff, state_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [IDX_W-1:0]     rev_k_ff, rev_k_in;
   logic [1:0]           qcnt_ff, qcnt_in;
   rsp_beat_type         q0_ff, q0_in, q1_ff, q1_in;

   logic [WORD_W-1:0]    entries [CAPACITY];
   cell_cmd_type         cell_cmd;
   cell_cmd_type         req_cmd;
   rsp_beat_type         new_beat;
   logic [CNT_W-1:0]     req_count;
   logic                 rev_start;
   logic                 accept;
   logic                 pop;
   op_type               op;
   logic [CMP_W-1:0]     pos_ext, cnt_ext, new_cnt_ext;
   logic [IDX_W-1:0]     pos_idx, cnt_idx;
   logic                 full, empty;
   logic [WORD_W-1:0]    rd_word;

   // handshake
   assign req_chan.ready = (state_ff == FSM_IDLE) && (qcnt_ff != 2'd2);
   assign accept         = req_chan.valid && req_chan.ready;
   assign pop            = rsp_chan.valid && rsp_chan.ready;

   assign op      = op_type'(req_chan.req_type);
   assign pos_ext = CMP_W'(req_chan.position);
   assign cnt_ext = CMP_W'(count_ff);
   assign pos_idx = pos_ext[IDX_W-1:0];
   assign cnt_idx = cnt_ext[IDX_W-1:0];
   assign full    = (count_ff == CNT_W'(CAPACITY));
   assign empty   = (count_ff == '0);

   // word at the requested position, one select per cell
   always_comb begin
      rd_word = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (pos_idx == IDX_W'(i)) begin
            rd_word = entries[i];
         end
      end
   end

   // decode the request into a cell command, new count and result beat
   always_comb begin
      req_cmd.op         = CELL_HOLD;
      req_cmd.pos        = '0;
      req_cmd.word       = req_chan.item_value;
      req_count          = count_ff;
      rev_start          = 1'b0;
      new_beat.status    = ST_OK;
      new_beat.read_value = '0;
      case (op)
         OP_PUSH_BACK: begin
            if (full) begin
               new_beat.status = ST_FULL;
            end else begin
               req_cmd.op  = CELL_INSERT;
               req_cmd.pos = cnt_idx;
               req_count   = count_ff + CNT_W'(1);
            end
         end
         OP_PUSH_FRONT: begin
            if (full) begin
               new_beat.status = ST_FULL;
            end else begin
               req_cmd.op  = CELL_INSERT;
               req_count   = count_ff + CNT_W'(1);
            end
         end
         OP_POP_BACK: begin
            if (empty) begin
               new_beat.status = ST_EMPTY;
            end else begin
               req_count = count_ff - CNT_W'(1);
            end
         end
         OP_POP_FRONT: begin
            if (empty) begin
               new_beat.status = ST_EMPTY;
            end else begin
               req_cmd.op = CELL_DELETE;
               req_count  = count_ff - CNT_W'(1);
            end
         end
         OP_INSERT_AT: begin
            if (pos_ext > cnt_ext) begin
               new_beat.status = ST_BADIDX;
            end else if (full) begin
               new_beat.status = ST_FULL;
            end else begin
               req_cmd.op  = CELL_INSERT;
               req_cmd.pos = pos_idx;
               req_count   = count_ff + CNT_W'(1);
            end
         end
         OP_DELETE_AT: begin
            if (empty) begin
               new_beat.status = ST_EMPTY;
            end else if (pos_ext >= cnt_ext) begin
               new_beat.status = ST_BADIDX;
            end else begin
               req_cmd.op  = CELL_DELETE;
               req_cmd.pos = pos_idx;
               req_count   = count_ff - CNT_W'(1);
            end
         end
         OP_REVERSE: begin
            rev_start = (count_ff > CNT_W'(1));
         end
         OP_READ_AT: begin
            if (empty) begin
               new_beat.status = ST_EMPTY;
            end else if (pos_ext >= cnt_ext) begin
               new_beat.status = ST_BADIDX;
            end else begin
               new_beat.read_value = rd_word;
            end
         end
         default: begin
            req_cmd.op = CELL_HOLD;
         end
      endcase
      new_cnt_ext         = CMP_W'(req_count);
      new_beat.item_count = new_cnt_ext[4:0];
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FSM_IDLE: begin
            if (accept && rev_start) begin
               state_in = FSM_REVERSE;
            end
         end
         FSM_REVERSE: begin
            if (rev_k_ff == IDX_W'(1)) begin
               state_in = FSM_IDLE;
            end
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

   // state outputs: cell command, pass counter, list count
   always_comb begin
      cell_cmd = req_cmd;
      rev_k_in = rev_k_ff;
      count_in = count_ff;
      case (state_ff)
         FSM_IDLE: begin
            if (accept) begin
               count_in = req_count;
               if (rev_start) begin
                  rev_k_in = cnt_idx - IDX_W'(1);
               end
            end else begin
               cell_cmd.op = CELL_HOLD;
            end
         end
         FSM_REVERSE: begin
            // rotate the first k+1 words left by one, head lands at k
            cell_cmd.op  = CELL_ROTATE;
            cell_cmd.pos = rev_k_ff;
            rev_k_in     = rev_k_ff - IDX_W'(1);
         end
         default: begin
            cell_cmd.op = CELL_HOLD;
         end
      endcase
   end

   // chain of cells
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [WORD_W-1:0] left_w, right_w;
      if (i == 0) begin : g_first
         assign left_w = '0;
      end else begin : g_mid_l
         assign left_w = entries[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign right_w = '0;
      end else begin : g_mid_r
         assign right_w = entries[i+1];
      end
      ile_cell u_cell (
         .clock       (clock),
         .cell_index  (IDX_W'(i)),
         .cmd         (cell_cmd),
         .left_entry  (left_w),
         .right_entry (right_w),
         .head_entry  (entries[0]),
         .entry       (entries[i])
      );
   end

   // two-beat output queue
   always_comb begin
      q0_in   = q0_ff;
      q1_in   = q1_ff;
      qcnt_in = qcnt_ff;
      case ({accept, pop})
         2'b10: begin
            if (qcnt_ff == 2'd0) begin
               q0_in = new_beat;
            end else begin
               q1_in = new_beat;
            end
            qcnt_in = qcnt_ff + 2'd1;
         end
         2'b01: begin
            q0_in   = q1_ff;
            qcnt_in = qcnt_ff - 2'd1;
         end
         2'b11: begin
            if (qcnt_ff == 2'd1) begin
               q0_in = new_beat;
            end else begin
               q0_in = q1_ff;
               q1_in = new_beat;
            end
         end
         default: begin
            qcnt_in = qcnt_ff;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FSM_IDLE;
         count_ff <= '0;
         qcnt_ff  <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         qcnt_ff  <= qcnt_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rev_k_ff <= rev_k_in;
      q0_ff    <= q0_in;
      q1_ff    <= q1_in;
   end

   assign rsp_chan.valid      = (qcnt_ff != 2'd0);
   assign rsp_chan.status     = q0_ff.status;
   assign rsp_chan.item_count = q0_ff.item_count;
   assign rsp_chan.read_value = q0_ff.read_value;

   `ASSERT_ALWAYS(a_queue_bound, qcnt_ff <= 2'd2)
   `ASSERT_ALWAYS(a_count_bound, count_ff <= CNT_W'(CAPACITY))
   `ASSERT_NEXT(a_rev_start, accept && rev_start, state_ff == FSM_REVERSE)
   `ASSERT_NEXT(a_rev_count, state_ff == FSM_REVERSE, $stable(count_ff))

endmodule

`default_nettype wire
